[src/mi_pkg.sv]
// shared constants for the 3x3 matrix inverse pipeline
package mi_pkg;

	localparam int ELEM_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int N_ELEM         = 9;
	localparam int N_TERM         = 3;

endpackage

[src/mi_mat_if.sv]
// valid/ready channels for the matrix word and the result word
interface mi_mat_if
	import mi_pkg::*;
	#(parameter int ELEM_WIDTH = ELEM_WIDTH_DEF) ();
	logic                         valid;
	logic                         ready;
	logic signed [ELEM_WIDTH-1:0] c0_r0, c0_r1, c0_r2;
	logic signed [ELEM_WIDTH-1:0] c1_r0, c1_r1, c1_r2;
	logic signed [ELEM_WIDTH-1:0] c2_r0, c2_r1, c2_r2;

	modport source (output valid, c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2,
		c2_r0, c2_r1, c2_r2, input ready);
	modport sink (input valid, c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2,
		c2_r0, c2_r1, c2_r2, output ready);
endinterface

interface mi_res_if
	import mi_pkg::*;
	#(parameter int ELEM_WIDTH = ELEM_WIDTH_DEF) ();
	logic                         valid;
	logic                         ready;
	logic signed [ELEM_WIDTH-1:0] inv_c0_r0, inv_c0_r1, inv_c0_r2;
	logic signed [ELEM_WIDTH-1:0] inv_c1_r0, inv_c1_r1, inv_c1_r2;
	logic signed [ELEM_WIDTH-1:0] inv_c2_r0, inv_c2_r1, inv_c2_r2;
	logic signed [ELEM_WIDTH-1:0] det_value;
	logic                         singular;
	logic                         saturated;

	modport source (output valid, inv_c0_r0, inv_c0_r1, inv_c0_r2, inv_c1_r0,
		inv_c1_r1, inv_c1_r2, inv_c2_r0, inv_c2_r1, inv_c2_r2, det_value,
		singular, saturated, input ready);
	modport sink (input valid, inv_c0_r0, inv_c0_r1, inv_c0_r2, inv_c1_r0,
		inv_c1_r1, inv_c1_r2, inv_c2_r0, inv_c2_r1, inv_c2_r2, det_value,
		singular, saturated, output ready);
endinterface

[src/matrix3_inverse_top.sv]
// top level of the pipelined 3x3 matrix inverse
// usage:
//  mat carries one 3x3 matrix word per handshake, column-major, nine signed
//  fixed-point elements; res carries the nine inverse elements, the rounded
//  determinant, a singular flag and a saturated flag
//  a word is taken when valid and ready are both high on a rising clk edge
//  throughput: one matrix word per cycle, no gaps, unless the pipe holds
//  the depth from acceptance to res.valid is set by the long division,
//  which resolves one quotient bit per stage
//  the whole pipe moves as one: when res holds a word the receiver has not
//  taken, every stage holds and mat.ready drops in the same cycle
//  arst_n clears all valid bits at once; the first word may follow directly
//  a zero determinant gives singular=1 with an all-zero inverse and
//  det_value=0; values beyond the element range clip and set saturated
module matrix3_inverse_top
	import mi_pkg::*;
#(
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	mi_mat_if.sink     mat,
	mi_res_if.source   res
);
	localparam int E     = ELEM_WIDTH;
	localparam int CW    = 2*E+1;
	localparam int DW    = 3*E+4;
	localparam int AW    = 4*E+2*FRAC_BITS+6;
	localparam int QW    = E+1;
	localparam int NSTEP = E+1;
	// sideband: lane signs, singular, det clipped, det value
	localparam int SBW   = N_ELEM+2+E;
	localparam int SB_SING = E+1;
	localparam int SB_DSAT = E;
	localparam int SB_NEG  = E+2;

	logic adv;

	// result register is the last stage; everything advances together
	logic                 out_valid_q;
	logic signed [E-1:0]  inv_q [N_ELEM];
	logic signed [E-1:0]  det_q;
	logic                 sing_q;
	logic                 sat_q;

	assign adv       = !out_valid_q || res.ready;
	assign mat.ready = adv;

	// input element array, column-major
	logic signed [E-1:0] m_in [N_ELEM];
	assign m_in[0] = mat.c0_r0;
	assign m_in[1] = mat.c0_r1;
	assign m_in[2] = mat.c0_r2;
	assign m_in[3] = mat.c1_r0;
	assign m_in[4] = mat.c1_r1;
	assign m_in[5] = mat.c1_r2;
	assign m_in[6] = mat.c2_r0;
	assign m_in[7] = mat.c2_r1;
	assign m_in[8] = mat.c2_r2;

	// cofactors, stages 1-2
	logic                 v_adj;
	logic signed [CW-1:0] cof_adj [N_ELEM];
	logic signed [E-1:0]  mcol [N_TERM];

	mi_adj #(.ELEM_WIDTH(E), .CW(CW)) u_adj (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(mat.valid), .m(m_in),
		.vout(v_adj), .cof(cof_adj), .mcol(mcol)
	);

	// determinant, stages 3-5
	logic                 v_det;
	logic signed [CW-1:0] cof_det [N_ELEM];
	logic signed [DW-1:0] det;

	mi_det #(.ELEM_WIDTH(E), .CW(CW), .DW(DW)) u_det (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(v_adj), .cof_in(cof_adj),
		.mcol(mcol), .vout(v_det), .cof_out(cof_det), .det(det)
	);

	// stage 6: magnitudes, rounded dividends, determinant output value
	logic          det_neg;
	logic [DW-1:0] dmag;
	logic [AW-1:0] dr;
	logic [AW-1:0] dlim;
	logic          dclip;
	logic [E-1:0]  dval;
	logic [AW-1:0] top_n [N_ELEM];
	logic [N_ELEM-1:0] negx;

	always_comb begin
		det_neg = det[DW-1];
		dmag    = det_neg ? DW'(-det) : DW'(det);
		// round half away on the magnitude
		dr      = (AW'(dmag) + (AW'(1) << (2*FRAC_BITS-1))) >> (2*FRAC_BITS);
		dlim    = det_neg ? (AW'(1) << (E-1)) : ((AW'(1) << (E-1)) - AW'(1));
		dclip   = dr > dlim;
		dval    = dclip ? dlim[E-1:0] : dr[E-1:0];
		if (det_neg)
			dval = E'(-dval);
		for (int l = 0; l < N_ELEM; l++) begin
			negx[l] = cof_det[l][CW-1] ^ det_neg;
			// 2*|cof|*2^(2F) + |det|, divided later by 2*|det|
			top_n[l] = (AW'(cof_det[l][CW-1] ? CW'(-cof_det[l]) : CW'(cof_det[l]))
				<< (2*FRAC_BITS+1)) + AW'(dmag);
		end
	end

	logic           v_s6;
	logic [AW-1:0]  top_s6 [N_ELEM];
	logic [AW-1:0]  den_s6;
	logic [SBW-1:0] side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_det;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			top_s6  <= top_n;
			den_s6  <= AW'(dmag) << 1;
			side_s6 <= {negx, (dmag == '0), dclip, dval};
		end
	end

	// division chain: first step tests for a quotient at or past 2^E
	logic           v_c [NSTEP+1];
	logic [AW-1:0]  rem_c [NSTEP+1][N_ELEM];
	logic [QW-1:0]  q_c [NSTEP+1][N_ELEM];
	logic [AW-1:0]  den_c [NSTEP+1];
	logic [SBW-1:0] side_c [NSTEP+1];

	assign v_c[0]    = v_s6;
	assign rem_c[0]  = top_s6;
	assign den_c[0]  = den_s6;
	assign side_c[0] = side_s6;
	assign q_c[0]    = '{default: '0};

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		mi_div_step #(.AW(AW), .QW(QW), .SHIFT(E-k), .SBW(SBW)) u_step (
			.clk(clk), .arst_n(arst_n), .en(adv), .vin(v_c[k]),
			.rem_in(rem_c[k]), .q_in(q_c[k]), .den_in(den_c[k]), .side_in(side_c[k]),
			.vout(v_c[k+1]), .rem_out(rem_c[k+1]), .q_out(q_c[k+1]),
			.den_out(den_c[k+1]), .side_out(side_c[k+1])
		);
	end

	// last stage: sign, clipping, singular override
	logic [SBW-1:0]    side_f;
	logic              sing_f;
	logic [N_ELEM-1:0] clip_f;
	logic [QW-1:0]     lim_f;
	logic [QW-1:0]     val_f;
	logic signed [E-1:0] inv_n [N_ELEM];

	always_comb begin
		side_f = side_c[NSTEP];
		sing_f = side_f[SB_SING];
		lim_f  = '0;
		val_f  = '0;
		for (int l = 0; l < N_ELEM; l++) begin
			lim_f = side_f[SB_NEG+l] ? (QW'(1) << (E-1)) : ((QW'(1) << (E-1)) - QW'(1));
			clip_f[l] = q_c[NSTEP][l] > lim_f;
			val_f = clip_f[l] ? lim_f : q_c[NSTEP][l];
			inv_n[l] = side_f[SB_NEG+l] ? E'(-val_f[E-1:0]) : val_f[E-1:0];
			if (sing_f)
				inv_n[l] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_c[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inv_q  <= inv_n;
			det_q  <= side_f[E-1:0];
			sing_q <= sing_f;
			sat_q  <= !sing_f && ((|clip_f) || side_f[SB_DSAT]);
		end
	end

	assign res.valid     = out_valid_q;
	assign res.inv_c0_r0 = inv_q[0];
	assign res.inv_c0_r1 = inv_q[1];
	assign res.inv_c0_r2 = inv_q[2];
	assign res.inv_c1_r0 = inv_q[3];
	assign res.inv_c1_r1 = inv_q[4];
	assign res.inv_c1_r2 = inv_q[5];
	assign res.inv_c2_r0 = inv_q[6];
	assign res.inv_c2_r1 = inv_q[7];
	assign res.inv_c2_r2 = inv_q[8];
	assign res.det_value = det_q;
	assign res.singular  = sing_q;
	assign res.saturated = sat_q;
endmodule

[src/mi_adj.sv]
// cofactor stages: pair products, then differences
module mi_adj
	import mi_pkg::*;
#(
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
	parameter int CW         = 2*ELEM_WIDTH_DEF+1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vin,
	input  logic signed [ELEM_WIDTH-1:0] m [N_ELEM],
	output logic                         vout,
	output logic signed [CW-1:0]         cof [N_ELEM],
	output logic signed [ELEM_WIDTH-1:0] mcol [N_TERM]
);
	localparam int PW = 2*ELEM_WIDTH;
	localparam int IA [N_ELEM] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
	localparam int IB [N_ELEM] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
	localparam int IC [N_ELEM] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
	localparam int ID [N_ELEM] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

	logic                         v_s1, v_s2;
	logic signed [PW-1:0]         pa_s1 [N_ELEM];
	logic signed [PW-1:0]         pb_s1 [N_ELEM];
	logic signed [ELEM_WIDTH-1:0] mc_s1 [N_TERM];
	logic signed [CW-1:0]         cof_s2 [N_ELEM];
	logic signed [ELEM_WIDTH-1:0] mc_s2 [N_TERM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_ELEM; i++) begin
				pa_s1[i]  <= PW'(m[IA[i]]) * PW'(m[IB[i]]);
				pb_s1[i]  <= PW'(m[IC[i]]) * PW'(m[ID[i]]);
				cof_s2[i] <= CW'(pa_s1[i]) - CW'(pb_s1[i]);
			end
			for (int j = 0; j < N_TERM; j++) begin
				mc_s1[j] <= m[j];
				mc_s2[j] <= mc_s1[j];
			end
		end
	end

	assign vout = v_s2;
	assign cof  = cof_s2;
	assign mcol = mc_s2;
endmodule

[src/mi_det.sv]
// determinant stages: split partial products, terms, sum
module mi_det
	import mi_pkg::*;
#(
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
	parameter int CW         = 2*ELEM_WIDTH_DEF+1,
	parameter int DW         = 3*ELEM_WIDTH_DEF+4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vin,
	input  logic signed [CW-1:0]         cof_in [N_ELEM],
	input  logic signed [ELEM_WIDTH-1:0] mcol [N_TERM],
	output logic                         vout,
	output logic signed [CW-1:0]         cof_out [N_ELEM],
	output logic signed [DW-1:0]         det
);
	localparam int HW = 2*ELEM_WIDTH+1;

	logic                 v_s3, v_s4, v_s5;
	logic signed [HW-1:0] pl_s3 [N_TERM];
	logic signed [HW-1:0] ph_s3 [N_TERM];
	logic signed [DW-1:0] term_s4 [N_TERM];
	logic signed [DW-1:0] det_s5;
	logic signed [CW-1:0] cof_s3 [N_ELEM];
	logic signed [CW-1:0] cof_s4 [N_ELEM];
	logic signed [CW-1:0] cof_s5 [N_ELEM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s3 <= vin;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// cofactor split into an unsigned low half and a signed high part
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < N_TERM; j++) begin
				pl_s3[j] <= HW'(mcol[j]) *
					HW'($signed({1'b0, cof_in[3*j][ELEM_WIDTH-1:0]}));
				ph_s3[j] <= HW'(mcol[j]) * HW'($signed(cof_in[3*j][CW-1:ELEM_WIDTH]));
				term_s4[j] <= (DW'(ph_s3[j]) <<< ELEM_WIDTH) + DW'(pl_s3[j]);
			end
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			cof_s3 <= cof_in;
			cof_s4 <= cof_s3;
			cof_s5 <= cof_s4;
		end
	end

	assign vout    = v_s5;
	assign cof_out = cof_s5;
	assign det     = det_s5;
endmodule

[src/mi_div_step.sv]
// one restoring division step for all nine lanes
module mi_div_step
	import mi_pkg::*;
#(
	parameter int AW    = 4*ELEM_WIDTH_DEF+2*FRAC_BITS_DEF+6,
	parameter int QW    = ELEM_WIDTH_DEF+1,
	parameter int SHIFT = 0,
	parameter int SBW   = 11+ELEM_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vin,
	input  logic [AW-1:0]  rem_in [N_ELEM],
	input  logic [QW-1:0]  q_in [N_ELEM],
	input  logic [AW-1:0]  den_in,
	input  logic [SBW-1:0] side_in,
	output logic           vout,
	output logic [AW-1:0]  rem_out [N_ELEM],
	output logic [QW-1:0]  q_out [N_ELEM],
	output logic [AW-1:0]  den_out,
	output logic [SBW-1:0] side_out
);
	logic          v_q;
	logic [AW-1:0] dsh;
	logic [AW-1:0] rem_n [N_ELEM];
	logic [QW-1:0] q_n [N_ELEM];

	assign dsh = den_in << SHIFT;

	always_comb begin
		for (int l = 0; l < N_ELEM; l++) begin
			if (rem_in[l] >= dsh) begin
				rem_n[l] = rem_in[l] - dsh;
				q_n[l]   = q_in[l] | (QW'(1) << SHIFT);
			end else begin
				rem_n[l] = rem_in[l];
				q_n[l]   = q_in[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= rem_n;
			q_out    <= q_n;
			den_out  <= den_in;
			side_out <= side_in;
		end
	end

	assign vout = v_q;
endmodule
